@@ rtl/cfa_pkg.sv @@
// ----------------------------------------------------------------------------
// cfa_pkg
// Shared types and constants of the contiguous fit allocator.
// ----------------------------------------------------------------------------
package cfa_pkg;

  localparam int DEF_MAX_SEGMENTS = 32;
  localparam int DEF_UNIT_BITS    = 16;
  localparam int RESULT_CAP       = 32;

  localparam logic [1:0] CMD_REQUEST = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_MERGE   = 2'd2;
  localparam logic [1:0] CMD_REPORT  = 2'd3;

  localparam logic [1:0] STRAT_FIRST = 2'd0;
  localparam logic [1:0] STRAT_BEST  = 2'd1;
  localparam logic [1:0] STRAT_WORST = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_SPACE = 3'd1;
  localparam logic [2:0] ST_DUP_ID   = 3'd2;
  localparam logic [2:0] ST_NOT_FND  = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_BAD_SIZE = 3'd5;

  // controller -> datapath commands
  typedef struct packed {
    logic init;      // reinitialize table
    logic load;      // latch input word
    logic scan_clr;  // restart scan pointer
    logic scan_step; // examine entry at pointer, advance
    logic shift_step;// move one entry up for split
    logic split;     // write chosen entry and remainder
    logic take;      // take chosen entry whole
    logic free;      // release found entry
    logic mrg_step;  // one merge compaction step
    logic mrg_done;  // commit merge count
    logic rep_step;  // advance report pointer
  } cfa_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic scan_end;   // pointer reached count
    logic dup;        // owner found
    logic fit_found;
    logic need_split;
    logic full;
    logic shift_end;
    logic rep_last;
  } cfa_sts_t;

endpackage

@@ rtl/cfa_datapath.sv @@
// ----------------------------------------------------------------------------
// cfa_datapath
// Segment table, scan pointer, fit selection, shift and merge datapath.
// ----------------------------------------------------------------------------
module cfa_datapath #(
  parameter int MAX_SEGMENTS = cfa_pkg::DEF_MAX_SEGMENTS,
  parameter int UNIT_BITS    = cfa_pkg::DEF_UNIT_BITS
) (
  input  logic            clk,
  input  logic            rst_n,
  input  cfa_pkg::cfa_cmd_t cmd,
  output cfa_pkg::cfa_sts_t sts,
  input  logic [15:0]     total_units,
  input  logic [1:0]      in_strategy,
  input  logic [15:0]     in_owner_id,
  input  logic [15:0]     in_req_size,
  output logic [4:0]      rd_index,
  output logic [15:0]     rd_base,
  output logic [15:0]     rd_size,
  output logic            rd_used,
  output logic [15:0]     rd_owner
);
  import cfa_pkg::*;

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);

  logic [UNIT_BITS-1:0] base_r  [MAX_SEGMENTS];
  logic [UNIT_BITS-1:0] size_r  [MAX_SEGMENTS];
  logic [15:0]          owner_r [MAX_SEGMENTS];
  logic [MAX_SEGMENTS-1:0] used_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] ptr_r;   // scan / read pointer
  logic [CW-1:0] wr_r;    // merge write pointer / shift pointer
  logic [IW-1:0] sel_r;
  logic          sel_vld_r;
  logic          dup_r;
  logic [UNIT_BITS-1:0] rsize_r;
  logic [15:0]   owner_q_r;
  logic [1:0]    strat_r;

  logic [IW-1:0] pi, wi, wi1;
  logic [UNIT_BITS-1:0] req_m;
  logic cand, better;

  assign pi    = ptr_r[IW-1:0];
  assign wi    = wr_r[IW-1:0];
  assign wi1   = IW'(wr_r - 1'b1);
  assign req_m = UNIT_BITS'(in_req_size);

  always_comb begin
    cand = !used_r[pi] && (size_r[pi] >= rsize_r);
    better = 1'b0;
    if (cand) begin
      if (!sel_vld_r) begin
        better = 1'b1;
      end else if (strat_r == STRAT_BEST) begin
        better = size_r[pi] < size_r[sel_r];
      end else if (strat_r == STRAT_WORST) begin
        better = size_r[pi] > size_r[sel_r];
      end
    end
  end

  always_comb begin
    sts.scan_end   = (ptr_r >= count_r);
    sts.dup        = dup_r;
    sts.fit_found  = sel_vld_r;
    sts.need_split = size_r[sel_r] > rsize_r;
    sts.full       = (count_r >= CW'(MAX_SEGMENTS));
    sts.shift_end  = (wr_r <= CW'(sel_r) + CW'(1));
    sts.rep_last   = (ptr_r + CW'(1) >= count_r) || (ptr_r + CW'(1) >= CW'(RESULT_CAP));
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.init) begin
      used_r  <= '0;
      count_r <= CW'(1);
      base_r[0]  <= '0;
      size_r[0]  <= rst_n ? UNIT_BITS'(total_units) : UNIT_BITS'(16'hFFFF);
      owner_r[0] <= '0;
      ptr_r   <= '0;
      wr_r    <= '0;
      sel_r   <= '0;
      sel_vld_r <= 1'b0;
      dup_r   <= 1'b0;
    end else begin
      if (cmd.load) begin
        rsize_r   <= req_m;
        owner_q_r <= in_owner_id;
        strat_r   <= in_strategy;
        ptr_r     <= '0;
        wr_r      <= count_r;
        sel_vld_r <= 1'b0;
        dup_r     <= 1'b0;
        sel_r     <= '0;
      end
      if (cmd.scan_clr) begin
        ptr_r <= CW'(1);
        wr_r  <= '0;
      end
      if (cmd.scan_step) begin
        ptr_r <= ptr_r + CW'(1);
        if (used_r[pi] && owner_r[pi] == owner_q_r && !dup_r) begin
          dup_r <= 1'b1;
          sel_r <= pi;
        end
        if (better && !dup_r) begin
          sel_vld_r <= 1'b1;
          sel_r     <= pi;
        end
      end
      if (cmd.shift_step) begin
        base_r[wi]  <= base_r[wi1];
        size_r[wi]  <= size_r[wi1];
        used_r[wi]  <= used_r[wi1];
        owner_r[wi] <= owner_r[wi1];
        wr_r <= wr_r - CW'(1);
      end
      if (cmd.split) begin
        base_r[IW'(sel_r + 1'b1)]  <= base_r[sel_r] + rsize_r;
        size_r[IW'(sel_r + 1'b1)]  <= size_r[sel_r] - rsize_r;
        used_r[IW'(sel_r + 1'b1)]  <= 1'b0;
        owner_r[IW'(sel_r + 1'b1)] <= '0;
        size_r[sel_r]  <= rsize_r;
        used_r[sel_r]  <= 1'b1;
        owner_r[sel_r] <= owner_q_r;
        count_r <= count_r + CW'(1);
      end
      if (cmd.take) begin
        used_r[sel_r]  <= 1'b1;
        owner_r[sel_r] <= owner_q_r;
      end
      if (cmd.free) begin
        used_r[sel_r]  <= 1'b0;
        owner_r[sel_r] <= '0;
      end
      if (cmd.mrg_step) begin
        // ptr_r = read index, wr_r = write index
        ptr_r <= ptr_r + CW'(1);
        if (!used_r[wi] && !used_r[pi]) begin
          size_r[wi] <= size_r[wi] + size_r[pi];
        end else begin
          wr_r <= wr_r + CW'(1);
          base_r[IW'(wr_r + 1'b1)]  <= base_r[pi];
          size_r[IW'(wr_r + 1'b1)]  <= size_r[pi];
          used_r[IW'(wr_r + 1'b1)]  <= used_r[pi];
          owner_r[IW'(wr_r + 1'b1)] <= owner_r[pi];
        end
      end
      if (cmd.mrg_done) begin
        count_r <= wr_r + CW'(1);
      end
      if (cmd.rep_step) begin
        ptr_r <= ptr_r + CW'(1);
      end
    end
  end

  logic [IW-1:0] ri;
  assign ri = cmd.rep_step ? pi : sel_r;

  always_comb begin
    rd_index = 5'(ri);
    rd_base  = 16'(base_r[ri]);
    rd_size  = 16'(size_r[ri]);
    rd_used  = used_r[ri];
    rd_owner = used_r[ri] ? owner_r[ri] : 16'd0;
  end

endmodule

@@ rtl/cfa_ctrl.sv @@
// ----------------------------------------------------------------------------
// cfa_ctrl
// Command sequencer and result register of the contiguous fit allocator.
// ----------------------------------------------------------------------------
module cfa_ctrl (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_req_size,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  output cfa_pkg::cfa_cmd_t cmd,
  input  cfa_pkg::cfa_sts_t sts,
  input  logic [4:0]  rd_index,
  input  logic [15:0] rd_base,
  input  logic [15:0] rd_size,
  input  logic        rd_used,
  input  logic [15:0] rd_owner,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [4:0]  out_seg_index,
  output logic [15:0] out_seg_base,
  output logic [15:0] out_seg_size,
  output logic        out_seg_used,
  output logic [15:0] out_seg_owner,
  output logic        out_last
);
  import cfa_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RSCAN = 4'd1;
  localparam logic [3:0] S_RDEC  = 4'd2;
  localparam logic [3:0] S_SHIFT = 4'd3;
  localparam logic [3:0] S_SPLIT = 4'd4;
  localparam logic [3:0] S_OKRES = 4'd5;
  localparam logic [3:0] S_LSCAN = 4'd6;
  localparam logic [3:0] S_LDEC  = 4'd7;
  localparam logic [3:0] S_MINIT = 4'd8;
  localparam logic [3:0] S_MSCAN = 4'd9;
  localparam logic [3:0] S_REP   = 4'd10;
  localparam logic [3:0] S_WAIT  = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic       ovld_r;
  logic       bad_r;
  logic       emit;
  logic [2:0] est;
  logic       elast, efields;

  assign in_stall  = (state_r != S_IDLE) || ovld_r;
  assign cfg_ready = (state_r == S_IDLE) && !ovld_r && !in_valid;
  assign out_valid = ovld_r;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    emit = 1'b0; est = ST_OK; elast = 1'b1; efields = 1'b0;
    cmd.init = cfg_valid && cfg_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.load = 1'b1;
          case (in_cmd)
            CMD_REQUEST: state_nxt = S_RSCAN;
            CMD_RELEASE: state_nxt = S_LSCAN;
            CMD_MERGE:   state_nxt = S_MINIT;
            default:     state_nxt = S_REP;
          endcase
        end
      end
      S_RSCAN: begin
        if (bad_r) begin
          emit = 1'b1; est = ST_BAD_SIZE; state_nxt = S_IDLE;
        end else if (sts.scan_end) begin
          state_nxt = S_RDEC;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_RDEC: begin
        if (sts.dup) begin
          emit = 1'b1; est = ST_DUP_ID; state_nxt = S_IDLE;
        end else if (!sts.fit_found) begin
          emit = 1'b1; est = ST_NO_SPACE; state_nxt = S_IDLE;
        end else if (sts.need_split && sts.full) begin
          emit = 1'b1; est = ST_FULL; state_nxt = S_IDLE;
        end else if (sts.need_split) begin
          state_nxt = S_SHIFT;
        end else begin
          cmd.take = 1'b1; state_nxt = S_OKRES;
        end
      end
      S_SHIFT: begin
        if (sts.shift_end) begin
          cmd.split = 1'b1; state_nxt = S_OKRES;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      S_OKRES: begin
        emit = 1'b1; efields = 1'b1; state_nxt = S_IDLE;
      end
      S_LSCAN: begin
        if (sts.scan_end) state_nxt = S_LDEC;
        else cmd.scan_step = 1'b1;
      end
      S_LDEC: begin
        if (sts.dup) begin
          cmd.free = 1'b1; state_nxt = S_OKRES;
        end else begin
          emit = 1'b1; est = ST_NOT_FND; state_nxt = S_IDLE;
        end
      end
      S_MINIT: begin
        cmd.scan_clr = 1'b1; state_nxt = S_MSCAN;
      end
      S_MSCAN: begin
        // write index starts at 0, read index at 1
        if (sts.scan_end) begin
          cmd.mrg_done = 1'b1; emit = 1'b1; state_nxt = S_IDLE;
        end else begin
          cmd.mrg_step = 1'b1;
        end
      end
      S_REP: begin
        emit = 1'b1; efields = 1'b1; elast = sts.rep_last;
        cmd.rep_step = 1'b1;
        state_nxt = sts.rep_last ? S_IDLE : S_WAIT;
      end
      S_WAIT: begin
        if (!ovld_r) state_nxt = S_REP;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (emit && ovld_r) begin
      // hold until result register drains
      cmd.rep_step = 1'b0; cmd.mrg_step = 1'b0; cmd.mrg_done = 1'b0;
      state_nxt = state_r;
      emit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovld_r  <= 1'b0;
      bad_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.load) begin
        bad_r <= (in_req_size == 16'd0);
      end
      if (ovld_r && !out_stall) ovld_r <= 1'b0;
      if (emit) ovld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_status    <= est;
      out_last      <= elast;
      out_seg_index <= efields ? rd_index : 5'd0;
      out_seg_base  <= efields ? rd_base  : 16'd0;
      out_seg_size  <= efields ? rd_size  : 16'd0;
      out_seg_used  <= efields ? rd_used  : 1'b0;
      out_seg_owner <= efields ? rd_owner : 16'd0;
    end
  end

endmodule

@@ rtl/contiguous_fit_allocator.sv @@
// ----------------------------------------------------------------------------
// contiguous_fit_allocator
// Request and release scan the whole table (a split request also shifts
// entries up); merge makes one pass over the table; a report gives one word
// per entry, up to RESULT_CAP words. One command at a time; the table scan
// sets throughput.
// Reset: synchronous; table holds one free segment of 65535 units.
// ----------------------------------------------------------------------------
module contiguous_fit_allocator #(
  parameter int MAX_SEGMENTS = cfa_pkg::DEF_MAX_SEGMENTS,
  parameter int UNIT_BITS    = cfa_pkg::DEF_UNIT_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_owner_id,
  input  logic [15:0] in_req_size,
  input  logic [1:0]  in_strategy,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_total_units,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [4:0]  out_seg_index,
  output logic [15:0] out_seg_base,
  output logic [15:0] out_seg_size,
  output logic        out_seg_used,
  output logic [15:0] out_seg_owner,
  output logic        out_last
);
  import cfa_pkg::*;

  cfa_cmd_t    cmd;
  cfa_sts_t    sts;
  logic [4:0]  rd_index;
  logic [15:0] rd_base, rd_size, rd_owner;
  logic        rd_used;

  cfa_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_cmd, .in_req_size,
    .cfg_valid, .cfg_ready, .cmd, .sts,
    .rd_index, .rd_base, .rd_size, .rd_used, .rd_owner,
    .out_valid, .out_stall, .out_status, .out_seg_index, .out_seg_base,
    .out_seg_size, .out_seg_used, .out_seg_owner, .out_last
  );

  cfa_datapath #(.MAX_SEGMENTS(MAX_SEGMENTS), .UNIT_BITS(UNIT_BITS)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .total_units(cfg_total_units), .in_strategy, .in_owner_id, .in_req_size,
    .rd_index, .rd_base, .rd_size, .rd_used, .rd_owner
  );

endmodule

@@ dv/tb_contiguous_fit_allocator.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_contiguous_fit_allocator
// Drives request, release, merge and report commands into the allocator and
// checks every result word against a segment table kept inside the bench.
// ----------------------------------------------------------------------------
module tb_contiguous_fit_allocator;
  import cfa_pkg::*;

  localparam int NSEG = 32;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  index;
    logic [15:0] base;
    logic [15:0] size;
    logic        used;
    logic [15:0] owner;
    logic        last;
  } seg_word_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_cmd;
  logic [15:0] in_owner_id;
  logic [15:0] in_req_size;
  logic [1:0]  in_strategy;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_total_units;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;
  logic [4:0]  out_seg_index;
  logic [15:0] out_seg_base;
  logic [15:0] out_seg_size;
  logic        out_seg_used;
  logic [15:0] out_seg_owner;
  logic        out_last;

  logic [15:0] tbl_base [NSEG];
  logic [15:0] tbl_size [NSEG];
  logic        tbl_used [NSEG];
  logic [15:0] tbl_owner [NSEG];
  int          tbl_count;
  seg_word_t   expected_words [$];
  logic [15:0] live_owners [$];
  int          errors;
  int          idle_cycles;
  int          stall_mode;

  contiguous_fit_allocator uut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic seg_word_t seg_word(int i, logic lst);
    seg_word_t w;
    w = '0;
    w.index = i[4:0];
    w.base = tbl_base[i];
    w.size = tbl_size[i];
    w.used = tbl_used[i];
    w.owner = tbl_used[i] ? tbl_owner[i] : 16'd0;
    w.last = lst;
    return w;
  endfunction

  function automatic seg_word_t err_word(logic [2:0] st);
    seg_word_t w;
    w = '0;
    w.status = st;
    w.last = 1'b1;
    return w;
  endfunction

  function automatic void table_init(logic [15:0] units);
    for (int i = 0; i < NSEG; i++) begin
      tbl_base[i] = '0;
      tbl_size[i] = '0;
      tbl_used[i] = 1'b0;
      tbl_owner[i] = '0;
    end
    tbl_size[0] = units;
    tbl_count = 1;
  endfunction

  function automatic int owner_slot(logic [15:0] id);
    for (int i = 0; i < tbl_count; i++)
      if (tbl_used[i] && tbl_owner[i] == id) return i;
    return -1;
  endfunction

  function automatic void allocator_predict(logic [1:0] cmd, logic [15:0] id,
                                            logic [15:0] sz, logic [1:0] strat);
    int f;
    int w;
    f = -1;
    case (cmd)
      CMD_REQUEST: begin
        if (sz == 0) begin
          expected_words.push_back(err_word(ST_BAD_SIZE));
        end else if (owner_slot(id) >= 0) begin
          expected_words.push_back(err_word(ST_DUP_ID));
        end else begin
          for (int i = 0; i < tbl_count; i++) begin
            if (tbl_used[i] || tbl_size[i] < sz) continue;
            if (f < 0) begin
              f = i;
              if (strat != STRAT_BEST && strat != STRAT_WORST) break;
            end else if (strat == STRAT_BEST && tbl_size[i] < tbl_size[f]) begin
              f = i;
            end else if (strat == STRAT_WORST && tbl_size[i] > tbl_size[f]) begin
              f = i;
            end
          end
          if (f < 0) begin
            expected_words.push_back(err_word(ST_NO_SPACE));
          end else if (tbl_size[f] > sz && tbl_count >= NSEG) begin
            expected_words.push_back(err_word(ST_FULL));
          end else begin
            if (tbl_size[f] > sz) begin
              for (int n = tbl_count; n > f + 1; n--) begin
                tbl_base[n] = tbl_base[n-1];
                tbl_size[n] = tbl_size[n-1];
                tbl_used[n] = tbl_used[n-1];
                tbl_owner[n] = tbl_owner[n-1];
              end
              tbl_base[f+1] = tbl_base[f] + sz;
              tbl_size[f+1] = tbl_size[f] - sz;
              tbl_used[f+1] = 1'b0;
              tbl_owner[f+1] = '0;
              tbl_size[f] = sz;
              tbl_count++;
            end
            tbl_used[f] = 1'b1;
            tbl_owner[f] = id;
            expected_words.push_back(seg_word(f, 1'b1));
          end
        end
      end
      CMD_RELEASE: begin
        f = owner_slot(id);
        if (f < 0) begin
          expected_words.push_back(err_word(ST_NOT_FND));
        end else begin
          tbl_used[f] = 1'b0;
          tbl_owner[f] = '0;
          expected_words.push_back(seg_word(f, 1'b1));
        end
      end
      CMD_MERGE: begin
        w = 0;
        for (int r = 1; r < tbl_count; r++) begin
          if (!tbl_used[w] && !tbl_used[r]) begin
            tbl_size[w] = tbl_size[w] + tbl_size[r];
          end else begin
            w++;
            tbl_base[w] = tbl_base[r];
            tbl_size[w] = tbl_size[r];
            tbl_used[w] = tbl_used[r];
            tbl_owner[w] = tbl_owner[r];
          end
        end
        tbl_count = w + 1;
        expected_words.push_back(err_word(ST_OK));
      end
      default: begin
        for (int i = 0; i < tbl_count; i++)
          expected_words.push_back(seg_word(i, i + 1 == tbl_count));
      end
    endcase
  endfunction

  task automatic send_command(logic [1:0] cmd, logic [15:0] id, logic [15:0] sz,
                              logic [1:0] strat);
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_owner_id <= id;
    in_req_size <= sz;
    in_strategy <= strat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    allocator_predict(cmd, id, sz, strat);
    if (cmd == CMD_REQUEST && expected_words[$].status == ST_OK) live_owners.push_back(id);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_total(logic [15:0] units);
    drain();
    cfg_valid <= 1'b1;
    cfg_total_units <= units;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    table_init(units);
    live_owners.delete();
  endtask

  task automatic random_command;
    int r;
    int k;
    logic [15:0] id;
    r = $urandom_range(0, 99);
    id = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 40));
    if (r < 50) begin
      send_command(CMD_REQUEST, id,
                   $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 3000)),
                   2'($urandom));
    end else if (r < 78) begin
      if (live_owners.size() != 0 && $urandom_range(0, 4) != 0) begin
        k = $urandom_range(0, live_owners.size() - 1);
        id = live_owners[k];
        live_owners.delete(k);
      end
      send_command(CMD_RELEASE, id, 16'($urandom), 2'($urandom));
    end else if (r < 90) begin
      send_command(CMD_MERGE, id, 16'($urandom), 2'($urandom));
    end else begin
      send_command(CMD_REPORT, id, 16'($urandom), 2'($urandom));
    end
    if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 12)) @(posedge clk);
  endtask

  task automatic test_directed;
    send_command(CMD_REPORT, 16'd0, 16'd0, STRAT_FIRST);
    send_command(CMD_REQUEST, 16'd1, 16'd0, STRAT_FIRST);
    send_command(CMD_REQUEST, 16'd1, 16'd100, STRAT_FIRST);
    send_command(CMD_REQUEST, 16'd1, 16'd5, STRAT_FIRST);
    send_command(CMD_REQUEST, 16'hFFFF, 16'd50, STRAT_BEST);
    send_command(CMD_REQUEST, 16'd3, 16'd200, STRAT_WORST);
    send_command(CMD_REQUEST, 16'd4, 16'hFFFF, 2'd3);
    send_command(CMD_RELEASE, 16'd1, 16'd0, STRAT_FIRST);
    send_command(CMD_RELEASE, 16'd1, 16'd0, STRAT_FIRST);
    send_command(CMD_RELEASE, 16'hFFFF, 16'd0, STRAT_FIRST);
    send_command(CMD_REQUEST, 16'd5, 16'd10, STRAT_BEST);
    send_command(CMD_REQUEST, 16'd6, 16'd90, STRAT_FIRST);
    send_command(CMD_REQUEST, 16'd7, 16'd30, STRAT_WORST);
    send_command(CMD_REPORT, 16'd0, 16'd0, STRAT_FIRST);
    send_command(CMD_MERGE, 16'd0, 16'd0, STRAT_FIRST);
    send_command(CMD_REPORT, 16'hFFFF, 16'hFFFF, 2'd3);
  endtask

  task automatic test_small_memory;
    write_total(16'd0);
    send_command(CMD_REQUEST, 16'd1, 16'd1, STRAT_FIRST);
    send_command(CMD_REPORT, 16'd0, 16'd0, STRAT_FIRST);
    write_total(16'd1);
    send_command(CMD_REQUEST, 16'd2, 16'd1, STRAT_BEST);
    send_command(CMD_REQUEST, 16'd3, 16'd1, STRAT_BEST);
    send_command(CMD_REPORT, 16'd0, 16'd0, STRAT_FIRST);
  endtask

  task automatic test_full_table;
    write_total(16'd1000);
    for (int i = 0; i < 34; i++) send_command(CMD_REQUEST, 16'(100 + i), 16'd3, STRAT_FIRST);
    send_command(CMD_REPORT, 16'd0, 16'd0, STRAT_FIRST);
    for (int i = 0; i < 31; i += 2) send_command(CMD_RELEASE, 16'(100 + i), 16'd0, STRAT_FIRST);
    send_command(CMD_REQUEST, 16'd500, 16'd2, STRAT_BEST);
    send_command(CMD_REQUEST, 16'd501, 16'd3, STRAT_WORST);
    send_command(CMD_MERGE, 16'd0, 16'd0, STRAT_FIRST);
    send_command(CMD_REPORT, 16'd0, 16'd0, STRAT_FIRST);
  endtask

  task automatic test_random(int units, int count);
    write_total(16'(units));
    for (int i = 0; i < count; i++) random_command();
  endtask

  task automatic test_pause;
    drain();
    send_command(CMD_REPORT, 16'd0, 16'd0, STRAT_FIRST);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_mode <= 0;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= $urandom_range(0, 3) == 0;
        default: out_stall <= $urandom_range(0, 1);
      endcase
    end
  end

  always @(posedge clk) begin
    seg_word_t got;
    seg_word_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_status, out_seg_index, out_seg_base, out_seg_size,
             out_seg_used, out_seg_owner, out_last};
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word %h", $time, got);
      end else begin
        exp_w = expected_words.pop_front();
        if (got !== exp_w) begin
          errors++;
          $display("%0t: mismatch expected st=%0d idx=%0d base=%0d size=%0d used=%0d own=%0d last=%0d",
                   $time, exp_w.status, exp_w.index, exp_w.base, exp_w.size,
                   exp_w.used, exp_w.owner, exp_w.last);
          $display("%0t:          actual   st=%0d idx=%0d base=%0d size=%0d used=%0d own=%0d last=%0d",
                   $time, got.status, got.index, got.base, got.size,
                   got.used, got.owner, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    errors = 0;
    idle_cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_REQUEST;
    in_owner_id = '0;
    in_req_size = '0;
    in_strategy = STRAT_FIRST;
    cfg_valid = 1'b0;
    cfg_total_units = '0;
    table_init(16'hFFFF);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_small_memory();
    test_full_table();
    test_random(65535, 130);
    test_pause();
    test_random(4000, 130);
    test_random(300, 80);
    test_random(16'hFFFF, 32);
    drain();
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
